// ===== src/hrdp_pkg.sv =====
// Shared types and constants of the HID report descriptor parser unit.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package hrdp_pkg;

	// One transaction on the input side.
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       last;
	} hrdp_in_t;

	// One result record.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] extracted;
		logic [7:0]         rpt_id;
		logic [15:0]        page_num;
		logic [15:0]        usage_code;
		logic [15:0]        usage_top;
		logic               is_array;
		logic signed [31:0] field_min;
		logic signed [31:0] logical_max;
		logic [6:0]         field_total;
		logic               overflowed;
		logic               last_result;
	} hrdp_res_t;

	localparam logic [1:0] KIND_SUMMARY = 2'd0;
	localparam logic [1:0] KIND_FIELD   = 2'd1;
	localparam logic [1:0] KIND_NONE    = 2'd2;

	localparam logic       ACTION_DESC = 1'b0;

	localparam logic [7:0] LONG_PREFIX = 8'hFE;

	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;

	localparam logic [3:0] TAG_INPUT  = 4'h8;
	localparam logic [3:0] TAG_PAGE   = 4'h0;
	localparam logic [3:0] TAG_LMIN   = 4'h1;
	localparam logic [3:0] TAG_LMAX   = 4'h2;
	localparam logic [3:0] TAG_RSIZE  = 4'h7;
	localparam logic [3:0] TAG_RID    = 4'h8;
	localparam logic [3:0] TAG_RCOUNT = 4'h9;
	localparam logic [3:0] TAG_PUSH   = 4'hA;
	localparam logic [3:0] TAG_POP    = 4'hB;
	localparam logic [3:0] TAG_USAGE  = 4'h0;
	localparam logic [3:0] TAG_UMIN   = 4'h1;
	localparam logic [3:0] TAG_UMAX   = 4'h2;

	// Records per report and bytes read per extracted field.
	localparam logic [6:0] RESULT_CAP = 7'd64;
	localparam logic [2:0] BYTE_SPAN  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic take;
		logic desc;
		logic look;
		logic add_step;
		logic add_fin;
		logic summary;
		logic rpt_store;
		logic dec_start;
		logic dec_id;
		logic fld_issue;
		logic fld_check;
		logic byte_step;
		logic emit_fld;
		logic done;
	} hrdp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic action;
		logic last;
		logic main_input;
		logic look_full;
		logic add_more;
		logic fld_left;
		logic fld_match;
		logic bytes_done;
	} hrdp_sts_t;

	// Data length of a short item from its prefix.
	function automatic logic [2:0] item_len(input logic [7:0] p);
		return (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
	endfunction

endpackage

// ===== src/hid_report_descriptor_parser_unit.sv =====
// Top level of the HID report descriptor parser unit.
// Instantiates hrdp_ctrl and hrdp_datapath; depends on hrdp_pkg.
//
// Usage: raise start with a transaction on item while busy is low; the item
// is taken at that edge. action 0 feeds a descriptor byte, action 1 a report
// byte; last marks the final byte of either. Results come out on result,
// each for exactly one cycle with result_valid high; last_result flags the
// final record caused by an item. The receiver cannot stall the block.
// Sequencing: a plain descriptor byte keeps busy high through the take and
// descriptor steps; an Input main item adds a cursor lookup, an add loop that
// writes the field entries (skipped when the report id table is full) and a
// finish step. A final descriptor byte adds a summary step. A report byte
// goes through the take and store steps; the final one adds decode start and
// id steps, an issue and a check step per field entry, byte reads (one report
// buffer read port, one byte per cycle) and an emit per match, and a done step.
// Reset clears the descriptor state; the first descriptor byte after reset
// or after a final descriptor byte starts a new field table.
module hid_report_descriptor_parser_unit #(
	parameter int MAX_FIELD_ENTRIES = 64,
	parameter int MAX_LOCAL_LIST    = 16,
	parameter int MAX_ID_CURSORS    = 8,
	parameter int PUSH_DEPTH        = 4,
	parameter int MAX_REPORT_LEN    = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  hrdp_pkg::hrdp_in_t  item,
	output logic                result_valid,
	output hrdp_pkg::hrdp_res_t result
);

	hrdp_pkg::hrdp_cmd_t cmd;
	hrdp_pkg::hrdp_sts_t sts;

	hrdp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	hrdp_datapath #(
		.MAX_FIELD_ENTRIES (MAX_FIELD_ENTRIES),
		.MAX_LOCAL_LIST    (MAX_LOCAL_LIST),
		.MAX_ID_CURSORS    (MAX_ID_CURSORS),
		.PUSH_DEPTH        (PUSH_DEPTH),
		.MAX_REPORT_LEN    (MAX_REPORT_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== src/hrdp_ctrl.sv =====
// Controller state machine of the HID report descriptor parser unit.
// Sequences the datapath through commands; depends on hrdp_pkg.
module hrdp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hrdp_pkg::hrdp_sts_t sts,
	output hrdp_pkg::hrdp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_TAKE, S_DESC, S_LOOK, S_ADD, S_FIN, S_SUM, S_RPT,
		S_DEC0, S_DEC1, S_FISS, S_FCHK, S_BYTES, S_EMIT, S_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_d  = (sts.action == hrdp_pkg::ACTION_DESC) ? S_DESC : S_RPT;
			end
			S_DESC: begin
				cmd.desc = 1'b1;
				if (sts.main_input) state_d = S_LOOK;
				else state_d = sts.last ? S_SUM : S_IDLE;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sts.look_full ? S_FIN : S_ADD;
			end
			S_ADD: begin
				cmd.add_step = sts.add_more;
				state_d      = sts.add_more ? S_ADD : S_FIN;
			end
			S_FIN: begin
				cmd.add_fin = 1'b1;
				state_d     = sts.last ? S_SUM : S_IDLE;
			end
			S_SUM: begin
				cmd.summary = 1'b1;
				state_d     = S_IDLE;
			end
			S_RPT: begin
				cmd.rpt_store = 1'b1;
				state_d       = sts.last ? S_DEC0 : S_IDLE;
			end
			S_DEC0: begin
				cmd.dec_start = 1'b1;
				state_d       = S_DEC1;
			end
			S_DEC1: begin
				cmd.dec_id = 1'b1;
				state_d    = S_FISS;
			end
			S_FISS: begin
				cmd.fld_issue = 1'b1;
				state_d       = sts.fld_left ? S_FCHK : S_DONE;
			end
			S_FCHK: begin
				cmd.fld_check = 1'b1;
				state_d       = sts.fld_match ? S_BYTES : S_FISS;
			end
			S_BYTES: begin
				cmd.byte_step = 1'b1;
				state_d       = sts.bytes_done ? S_EMIT : S_BYTES;
			end
			S_EMIT: begin
				cmd.emit_fld = 1'b1;
				state_d      = S_FISS;
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== src/hrdp_datapath.sv =====
// Datapath of the HID report descriptor parser unit: item walker, globals,
// push stack, locals, id cursors, field table, report buffer and extractor.
// Depends on hrdp_pkg; driven by hrdp_ctrl.
module hrdp_datapath #(
	parameter int MAX_FIELD_ENTRIES = 64,
	parameter int MAX_LOCAL_LIST    = 16,
	parameter int MAX_ID_CURSORS    = 8,
	parameter int PUSH_DEPTH        = 4,
	parameter int MAX_REPORT_LEN    = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hrdp_pkg::hrdp_in_t  item,
	input  hrdp_pkg::hrdp_cmd_t cmd,
	output hrdp_pkg::hrdp_sts_t sts,
	output logic                result_valid,
	output hrdp_pkg::hrdp_res_t result
);

	localparam int FI = (MAX_FIELD_ENTRIES > 1) ? $clog2(MAX_FIELD_ENTRIES) : 1;
	localparam int FC = $clog2(MAX_FIELD_ENTRIES + 1);
	localparam int LI = (MAX_LOCAL_LIST > 1) ? $clog2(MAX_LOCAL_LIST) : 1;
	localparam int LC = $clog2(MAX_LOCAL_LIST + 1);
	localparam int CI = (MAX_ID_CURSORS > 1) ? $clog2(MAX_ID_CURSORS) : 1;
	localparam int CC = $clog2(MAX_ID_CURSORS + 1);
	localparam int SI = (PUSH_DEPTH > 1) ? $clog2(PUSH_DEPTH) : 1;
	localparam int SC = $clog2(PUSH_DEPTH + 1);
	localparam int BI = $clog2(MAX_REPORT_LEN);
	localparam int BC = $clog2(MAX_REPORT_LEN + 1);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_DATA  = 2'd1;
	localparam logic [1:0] PH_LSIZE = 2'd2;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] off;
		logic [7:0]  size;
		logic [31:0] fmin;
		logic [31:0] fmax;
		logic [15:0] page;
		logic [15:0] code;
		logic [15:0] top;
		logic        arr;
	} fent_t;

	typedef struct packed {
		logic [31:0] gmin;
		logic [31:0] gmax;
		logic [31:0] graw;
		logic [15:0] page;
		logic [7:0]  size;
		logic [15:0] count;
		logic [7:0]  id;
	} gstk_t;

	hrdp_pkg::hrdp_in_t in_q;

	// Item walker
	logic [1:0]  ph_q, ph_d;
	logic [7:0]  pre_q, pre_d;
	logic [31:0] dat_q, dat_d;
	logic [8:0]  bl_q, bl_d;
	logic        newdesc_q;

	// Globals and stack
	logic [15:0] g_page_q, g_count_q;
	logic [31:0] g_min_q, g_max_q, g_raw_q;
	logic [7:0]  g_size_q, g_id_q;
	logic [SC-1:0] sdep_q;
	gstk_t       stk_q [PUSH_DEPTH];

	// Locals
	logic [LC-1:0] lcnt_q;
	logic [31:0] lst_q [MAX_LOCAL_LIST];
	logic [15:0] rlo_q, rhi_q;
	logic        rseen_q;

	// Id cursors
	logic [CC-1:0] ctot_q;
	logic [7:0]  cid_q [MAX_ID_CURSORS];
	logic [15:0] cbits_q [MAX_ID_CURSORS];

	// Field table
	logic [FC-1:0] fcnt_q;
	fent_t       fmem [MAX_FIELD_ENTRIES];
	fent_t       fe_q;
	logic        ids_q, ovf_q;

	// Report buffer
	logic [BC-1:0] rlen_q;
	logic [7:0]  rbuf [MAX_REPORT_LEN];
	logic [7:0]  rd_q;
	logic        rdv_q;

	// Field insertion loop
	logic [1:0]  flags_q;
	logic [CI-1:0] ci_q;
	logic [15:0] base_q, cur_q, an_q;
	logic        full_q;

	// Report decode loop
	logic [FC-1:0] dn_q;
	logic [6:0]  k_q;
	logic [7:0]  id_q;
	logic        p0_q;
	logic [BC-1:0] plen_q;
	logic [2:0]  sh_q, j_q;
	logic [13:0] bp_q;
	logic [39:0] acc_q;
	hrdp_pkg::hrdp_res_t pend_q;
	logic        pv_q;

	hrdp_pkg::hrdp_res_t res_q;
	logic        rv_q;

	// ---------------------------------------------------------------
	// Descriptor byte step
	logic        run_en;
	logic [7:0]  run_pre;
	logic [31:0] run_raw;
	logic [2:0]  k3;
	logic [7:0]  b;

	always_comb begin
		b       = in_q.data_byte;
		ph_d    = ph_q;
		pre_d   = pre_q;
		dat_d   = dat_q;
		bl_d    = bl_q;
		run_en  = 1'b0;
		run_pre = pre_q;
		run_raw = dat_q;
		k3      = hrdp_pkg::item_len(pre_q) - bl_q[2:0];
		case (ph_q)
			PH_IDLE: begin
				if (b == hrdp_pkg::LONG_PREFIX) begin
					ph_d = PH_LSIZE;
				end else begin
					pre_d   = b;
					dat_d   = '0;
					run_pre = b;
					if (hrdp_pkg::item_len(b) == 3'd0) begin
						run_en  = 1'b1;
						run_raw = '0;
					end else begin
						bl_d = 9'(hrdp_pkg::item_len(b));
						ph_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				dat_d = dat_q | (32'(b) << {k3[1:0], 3'b000});
				bl_d  = bl_q - 9'd1;
				if (bl_d == 9'd0) begin
					ph_d    = PH_IDLE;
					run_en  = 1'b1;
					run_raw = dat_d;
				end
			end
			PH_LSIZE: begin
				bl_d = 9'(b) + 9'd1;
				ph_d = 2'd3;
			end
			default: begin
				if (bl_q != 9'd0) bl_d = bl_q - 9'd1;
				if (bl_d == 9'd0) ph_d = PH_IDLE;
			end
		endcase
	end

	logic [2:0]  r_len;
	logic [1:0]  r_type;
	logic [3:0]  r_tag;
	logic [31:0] sval;
	logic        do_g, do_l, do_m, is_input, push_we, pop_en, usage_we;
	logic [SC-1:0] sdep_m1;
	gstk_t       stk_top;
	logic [15:0] u_page;

	always_comb begin
		r_len  = hrdp_pkg::item_len(run_pre);
		r_type = run_pre[3:2];
		r_tag  = run_pre[7:4];
		sval   = run_raw;
		if (r_len == 3'd1 && run_raw[7]) sval = run_raw | 32'hFFFFFF00;
		if (r_len == 3'd2 && run_raw[15]) sval = run_raw | 32'hFFFF0000;
	end

	assign do_g     = cmd.desc && run_en && (r_type == hrdp_pkg::TYPE_GLOBAL);
	assign do_l     = cmd.desc && run_en && (r_type == hrdp_pkg::TYPE_LOCAL);
	assign do_m     = cmd.desc && run_en && (r_type == hrdp_pkg::TYPE_MAIN);
	assign is_input = do_m && (r_tag == hrdp_pkg::TAG_INPUT) && (g_size_q != 8'd0);
	assign push_we  = do_g && (r_tag == hrdp_pkg::TAG_PUSH) && (sdep_q < SC'(PUSH_DEPTH));
	assign pop_en   = do_g && (r_tag == hrdp_pkg::TAG_POP) && (sdep_q != '0);
	assign usage_we = do_l && (r_tag == hrdp_pkg::TAG_USAGE) &&
	                  (lcnt_q < LC'(MAX_LOCAL_LIST));
	assign sdep_m1  = sdep_q - SC'(1);
	assign stk_top  = stk_q[sdep_m1[SI-1:0]];
	assign u_page   = (r_len == 3'd4) ? run_raw[31:16] : g_page_q;

	// ---------------------------------------------------------------
	// Cursor lookup: the last cursor with the current id wins.
	logic          found;
	logic [CI-1:0] fidx;
	logic          look_full;

	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int c = 0; c < MAX_ID_CURSORS; c++) begin
			if (CC'(c) < ctot_q && cid_q[c] == g_id_q) begin
				found = 1'b1;
				fidx  = CI'(c);
			end
		end
	end

	assign look_full = !found && (ctot_q >= CC'(MAX_ID_CURSORS));

	// ---------------------------------------------------------------
	// Field entry for the current instance of an Input item.
	logic          add_more, in_list;
	logic [LC-1:0] lcnt_m1;
	logic [LI-1:0] lsel;
	logic [31:0]   lent;
	logic [16:0]   u_sum;
	logic [15:0]   u_clip;
	logic [23:0]   prod;
	fent_t         new_ent;

	assign add_more = !flags_q[0] && (an_q < g_count_q) && (fcnt_q < FC'(MAX_FIELD_ENTRIES));
	assign in_list  = an_q < 16'(lcnt_q);
	assign lcnt_m1  = lcnt_q - LC'(1);
	assign lsel     = in_list ? an_q[LI-1:0] : lcnt_m1[LI-1:0];
	assign lent     = lst_q[lsel];
	assign u_sum    = 17'(rlo_q) + 17'(an_q);
	assign u_clip   = (u_sum > 17'(rhi_q)) ? rhi_q : u_sum[15:0];
	assign prod     = 24'(g_size_q) * 24'(g_count_q);

	always_comb begin
		new_ent      = '0;
		new_ent.id   = g_id_q;
		new_ent.off  = cur_q;
		new_ent.size = g_size_q;
		new_ent.fmin = g_min_q;
		new_ent.fmax = (!g_min_q[31] && g_max_q[31]) ? g_raw_q : g_max_q;
		if (flags_q[1]) begin
			if (in_list || (!rseen_q && lcnt_q != '0)) begin
				new_ent.page = lent[31:16];
				new_ent.code = lent[15:0];
			end else if (rseen_q) begin
				new_ent.page = g_page_q;
				new_ent.code = u_clip;
			end else begin
				new_ent.page = g_page_q;
				new_ent.code = 16'd0;
			end
			new_ent.top = new_ent.code;
			new_ent.arr = 1'b0;
		end else begin
			new_ent.page = g_page_q;
			new_ent.code = rlo_q;
			new_ent.top  = rhi_q;
			new_ent.arr  = 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Report decode
	logic          fld_left, fld_match, bytes_done, rd_en, rd_ok;
	logic [14:0]   rd_addr;
	logic [2:0]    jm;
	logic [39:0]   shifted;
	logic [31:0]   vraw, vmask, vext;
	logic          vsgn;
	logic [4:0]    topbit;
	hrdp_pkg::hrdp_res_t fld_rec;

	assign fld_left   = (dn_q < fcnt_q) && (k_q < hrdp_pkg::RESULT_CAP);
	assign fld_match  = (fe_q.id == id_q) && (fe_q.size != 8'd0) && (fe_q.size <= 8'd32) &&
	                    ((17'(fe_q.off) + 17'(fe_q.size)) <= 17'({plen_q, 3'b000}));
	assign bytes_done = (j_q == hrdp_pkg::BYTE_SPAN);
	assign rd_en      = cmd.dec_start || (cmd.byte_step && j_q < hrdp_pkg::BYTE_SPAN);
	assign rd_addr    = cmd.dec_start ? 15'd0 : (15'(bp_q) + 15'(j_q));
	assign rd_ok      = rd_addr < 15'(MAX_REPORT_LEN);
	assign jm         = j_q - 3'd1;

	assign shifted = acc_q >> sh_q;
	assign vraw    = shifted[31:0];
	assign vmask   = (fe_q.size >= 8'd32) ? 32'hFFFFFFFF :
	                 ((32'd1 << fe_q.size[4:0]) - 32'd1);
	assign topbit  = fe_q.size[4:0] - 5'd1;
	assign vsgn    = fe_q.fmin[31] && (fe_q.size < 8'd32) && vraw[topbit];
	assign vext    = (vraw & vmask) | (vsgn ? ~vmask : 32'd0);

	always_comb begin
		fld_rec             = '0;
		fld_rec.kind        = hrdp_pkg::KIND_FIELD;
		fld_rec.extracted   = vext;
		fld_rec.rpt_id      = id_q;
		fld_rec.page_num    = fe_q.page;
		fld_rec.usage_code  = fe_q.code;
		fld_rec.usage_top   = fe_q.top;
		fld_rec.is_array    = fe_q.arr;
		fld_rec.field_min   = fe_q.fmin;
		fld_rec.logical_max = fe_q.fmax;
	end

	// ---------------------------------------------------------------
	// Control and global registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_IDLE;
			pre_q     <= '0;
			dat_q     <= '0;
			bl_q      <= '0;
			newdesc_q <= 1'b1;
			g_page_q  <= '0;
			g_min_q   <= '0;
			g_max_q   <= '0;
			g_raw_q   <= '0;
			g_size_q  <= '0;
			g_count_q <= '0;
			g_id_q    <= '0;
			sdep_q    <= '0;
			lcnt_q    <= '0;
			rlo_q     <= '0;
			rhi_q     <= '0;
			rseen_q   <= 1'b0;
			ctot_q    <= '0;
			fcnt_q    <= '0;
			ids_q     <= 1'b0;
			ovf_q     <= 1'b0;
			rlen_q    <= '0;
			flags_q   <= '0;
			ci_q      <= '0;
			base_q    <= '0;
			cur_q     <= '0;
			an_q      <= '0;
			full_q    <= 1'b0;
			dn_q      <= '0;
			k_q       <= '0;
			id_q      <= '0;
			p0_q      <= 1'b0;
			plen_q    <= '0;
			sh_q      <= '0;
			bp_q      <= '0;
			j_q       <= '0;
			pv_q      <= 1'b0;
			rv_q      <= 1'b0;
		end else begin
			rv_q <= cmd.summary || (cmd.emit_fld && pv_q) || cmd.done;

			// The first descriptor byte of a new descriptor wipes the old one.
			if (cmd.take && in_q.action == hrdp_pkg::ACTION_DESC && newdesc_q) begin
				newdesc_q <= 1'b0;
				ph_q      <= PH_IDLE;
				pre_q     <= '0;
				dat_q     <= '0;
				bl_q      <= '0;
				g_page_q  <= '0;
				g_min_q   <= '0;
				g_max_q   <= '0;
				g_raw_q   <= '0;
				g_size_q  <= '0;
				g_count_q <= '0;
				g_id_q    <= '0;
				sdep_q    <= '0;
				lcnt_q    <= '0;
				rlo_q     <= '0;
				rhi_q     <= '0;
				rseen_q   <= 1'b0;
				ctot_q    <= '0;
				fcnt_q    <= '0;
				ids_q     <= 1'b0;
				ovf_q     <= 1'b0;
			end

			if (cmd.desc) begin
				ph_q    <= ph_d;
				pre_q   <= pre_d;
				dat_q   <= dat_d;
				bl_q    <= bl_d;
				flags_q <= run_raw[1:0];
			end

			if (do_g) begin
				case (r_tag)
					hrdp_pkg::TAG_PAGE:   g_page_q <= run_raw[15:0];
					hrdp_pkg::TAG_LMIN:   g_min_q <= sval;
					hrdp_pkg::TAG_LMAX: begin
						g_max_q <= sval;
						g_raw_q <= run_raw;
					end
					hrdp_pkg::TAG_RSIZE:  g_size_q <= run_raw[7:0];
					hrdp_pkg::TAG_RID: begin
						g_id_q <= run_raw[7:0];
						ids_q  <= 1'b1;
					end
					hrdp_pkg::TAG_RCOUNT: g_count_q <= run_raw[15:0];
					hrdp_pkg::TAG_PUSH: begin
						if (push_we) sdep_q <= sdep_q + SC'(1);
					end
					hrdp_pkg::TAG_POP: begin
						if (pop_en) begin
							sdep_q    <= sdep_m1;
							g_min_q   <= stk_top.gmin;
							g_max_q   <= stk_top.gmax;
							g_raw_q   <= stk_top.graw;
							g_page_q  <= stk_top.page;
							g_size_q  <= stk_top.size;
							g_count_q <= stk_top.count;
							g_id_q    <= stk_top.id;
						end
					end
					default: ;
				endcase
			end

			if (do_l) begin
				case (r_tag)
					hrdp_pkg::TAG_USAGE: begin
						if (usage_we) lcnt_q <= lcnt_q + LC'(1);
					end
					hrdp_pkg::TAG_UMIN: begin
						rlo_q   <= run_raw[15:0];
						rseen_q <= 1'b1;
					end
					hrdp_pkg::TAG_UMAX: begin
						rhi_q   <= run_raw[15:0];
						rseen_q <= 1'b1;
					end
					default: ;
				endcase
			end

			// An Input item keeps its locals until its fields are entered.
			if ((do_m && !is_input) || cmd.add_fin) begin
				lcnt_q  <= '0;
				rlo_q   <= '0;
				rhi_q   <= '0;
				rseen_q <= 1'b0;
			end

			if (cmd.look) begin
				full_q <= look_full;
				an_q   <= '0;
				if (found) begin
					ci_q   <= fidx;
					base_q <= cbits_q[fidx];
					cur_q  <= cbits_q[fidx];
				end else if (!look_full) begin
					ci_q   <= ctot_q[CI-1:0];
					base_q <= '0;
					cur_q  <= '0;
					ctot_q <= ctot_q + CC'(1);
				end
			end

			if (cmd.add_step) begin
				fcnt_q <= fcnt_q + FC'(1);
				an_q   <= an_q + 16'd1;
				cur_q  <= cur_q + 16'(g_size_q);
			end

			// Left-over instances (field table full) or a full id cursor table flag an overflow.
			if (cmd.add_fin) begin
				if (full_q || (!flags_q[0] && an_q < g_count_q)) ovf_q <= 1'b1;
			end

			if (cmd.summary) begin
				newdesc_q <= 1'b1;
				ph_q      <= PH_IDLE;
				bl_q      <= '0;
			end

			if (cmd.rpt_store && rlen_q < BC'(MAX_REPORT_LEN)) rlen_q <= rlen_q + BC'(1);

			if (cmd.dec_start) begin
				dn_q <= '0;
				k_q  <= '0;
				pv_q <= 1'b0;
			end

			if (cmd.dec_id) begin
				if (ids_q && rlen_q != '0) begin
					id_q   <= rd_q;
					p0_q   <= 1'b1;
					plen_q <= rlen_q - BC'(1);
				end else begin
					id_q   <= '0;
					p0_q   <= 1'b0;
					plen_q <= rlen_q;
				end
			end

			if (cmd.fld_check) begin
				if (fld_match) begin
					j_q  <= '0;
					sh_q <= fe_q.off[2:0];
					bp_q <= 14'(p0_q) + 14'(fe_q.off[15:3]);
				end else begin
					dn_q <= dn_q + FC'(1);
				end
			end

			if (cmd.byte_step) j_q <= j_q + 3'd1;

			if (cmd.emit_fld) begin
				pv_q <= 1'b1;
				k_q  <= k_q + 7'd1;
				dn_q <= dn_q + FC'(1);
			end

			if (cmd.done) begin
				rlen_q <= '0;
				pv_q   <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Payload registers and register arrays
	always_ff @(posedge clk) begin
		if (cmd.latch) in_q <= item;
		if (push_we) begin
			stk_q[sdep_q[SI-1:0]] <= '{gmin: g_min_q, gmax: g_max_q, graw: g_raw_q,
			                          page: g_page_q, size: g_size_q,
			                          count: g_count_q, id: g_id_q};
		end
		if (usage_we) lst_q[lcnt_q[LI-1:0]] <= {u_page, run_raw[15:0]};
		if (cmd.look && !found && !look_full) begin
			cid_q[ctot_q[CI-1:0]]   <= g_id_q;
			cbits_q[ctot_q[CI-1:0]] <= '0;
		end
		if (cmd.add_fin && !full_q) cbits_q[ci_q] <= base_q + prod[15:0];
	end

	// Field table memory
	always_ff @(posedge clk) begin
		if (cmd.add_step) fmem[fcnt_q[FI-1:0]] <= new_ent;
		if (cmd.fld_issue) fe_q <= fmem[dn_q[FI-1:0]];
	end

	// Report buffer memory
	always_ff @(posedge clk) begin
		if (cmd.rpt_store && rlen_q < BC'(MAX_REPORT_LEN)) begin
			rbuf[rlen_q[BI-1:0]] <= in_q.data_byte;
		end
		if (rd_en) begin
			rd_q  <= rbuf[rd_addr[BI-1:0]];
			rdv_q <= rd_ok;
		end
	end

	// Byte assembly and record output
	always_ff @(posedge clk) begin
		if (cmd.fld_check) acc_q <= '0;
		if (cmd.byte_step && j_q != 3'd0) acc_q[{jm, 3'b000} +: 8] <= rdv_q ? rd_q : 8'd0;
		if (cmd.emit_fld) begin
			pend_q <= fld_rec;
			res_q  <= pend_q;
		end
		if (cmd.summary) begin
			res_q             <= '0;
			res_q.kind        <= hrdp_pkg::KIND_SUMMARY;
			res_q.field_total <= 7'(fcnt_q);
			res_q.overflowed  <= ovf_q;
			res_q.last_result <= 1'b1;
		end
		if (cmd.done) begin
			if (pv_q) begin
				res_q             <= pend_q;
				res_q.last_result <= 1'b1;
			end else begin
				res_q             <= '0;
				res_q.kind        <= hrdp_pkg::KIND_NONE;
				res_q.rpt_id      <= id_q;
				res_q.last_result <= 1'b1;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.action     = in_q.action;
		sts.last       = in_q.last;
		sts.main_input = is_input;
		sts.look_full  = look_full;
		sts.add_more   = add_more;
		sts.fld_left   = fld_left;
		sts.fld_match  = fld_match;
		sts.bytes_done = bytes_done;
	end

	assign result_valid = rv_q;
	assign result       = res_q;

endmodule

// ===== src/hrdp_checker.sv =====
// Port-level checker of the HID report descriptor parser unit and its bind.
// Depends on hrdp_pkg and hid_report_descriptor_parser_unit.
module hrdp_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                result_valid,
	input hrdp_pkg::hrdp_res_t result
);

	// An accepted transaction always keeps the block busy for the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// Records never come out in two adjacent cycles.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	// The final record of a transaction coincides with the return to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_result |-> !busy)
		else $error("busy after final record");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> busy)
		else $error("idle while records remain");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == hrdp_pkg::KIND_SUMMARY |-> result.last_result)
		else $error("summary record not marked last");

endmodule

bind hid_report_descriptor_parser_unit hrdp_port_checker u_hrdp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
